@@ rtl/core/rational_arith_gcd_reduce_macros.svh @@
// Assertion macros shared by the fraction unit.
`ifndef RATIONAL_ARITH_GCD_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_GCD_REDUCE_MACROS_SVH
// Implication checked each clock, quiet during reset.
`define RAG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, quiet during reset.
`define RAG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/rag_pkg.sv @@
// Package with the command codes, state type and shared types of the fraction unit.
package rag_pkg;
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2,
    CMD_DIV = 3'd3, CMD_NEG = 3'd4, CMD_RED = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_GCD_START, ST_GCD_WAIT,
    ST_QN_START, ST_QN_WAIT, ST_QD_START, ST_QD_WAIT, ST_OUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // Answer of the shared divider.
  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

@@ rtl/core/rag_divider.sv @@
// Shared radix-2 truncated signed divider, one quotient bit per cycle.
module rag_divider (
  input  logic              clk,
  input  logic              rst,
  input  rag_pkg::div_req_t req,
  output rag_pkg::div_rsp_t rsp
);
  import rag_pkg::*;

  logic [31:0] q;
  logic [32:0] r;
  logic [31:0] dmag;
  logic [5:0]  cnt;
  logic        busy;
  logic        qneg;
  logic        rneg;
  logic        done;
  logic [32:0] trial;
  logic [32:0] rsh;

  // One restoring step on the running remainder.
  always_comb begin
    rsh   = {r[31:0], q[31]};
    trial = rsh - {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        q    <= req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
        dmag <= req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
        r    <= '0;
        qneg <= req.dividend[31] ^ req.divisor[31];
        rneg <= req.dividend[31];
      end else if (busy) begin
        if (trial[32]) begin
          r <= rsh;
          q <= {q[30:0], 1'b0};
        end else begin
          r <= trial;
          q <= {q[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Signs follow truncated division.
  assign rsp.done = done;
  assign rsp.quot = qneg ? 32'd0 - q : q;
  assign rsp.rem  = rneg ? 32'd0 - r[31:0] : r[31:0];
endmodule

@@ rtl/core/rag_multiplier.sv @@
// Registered 32x32 multiplier keeping the low 32 bits.
module rag_multiplier (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [31:0] prod
);
  // One product per cycle, wrapped modulo 2^32.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end
endmodule

@@ rtl/core/rational_arith_gcd_reduce.sv @@
// Top level of the fraction unit: sequencer around a shared multiplier and divider.
//
// Usage: one input beat on s_axis carries a command and two fractions; one output
// beat on m_axis carries the resulting fraction and a zero-denominator flag.
// Add, sub, mul and div use the one shared multiplier through states ST_MUL1 to
// ST_MUL4 and then raise m_axis_tvalid. Negate, unknown commands and reduce
// with a zero denominator raise it on the next cycle. Reduce runs the Euclid loop
// on the shared 32-step divider, then divides numerator and denominator by
// the gcd unless it is 1; the number of Euclid divisions (k, up to about 46)
// and the divider loop set when m_axis_tvalid rises after acceptance.
// The block takes one item at a time: s_axis_tready is high only while idle, and
// it returns high on the cycle after the result beat is taken.
// The result beat is held in the output register until m_axis_tready; the block
// waits and accepts nothing meanwhile. A synchronous reset returns the sequencer
// to idle and drops any beat in progress; no clearing pass is needed.
module rational_arith_gcd_reduce (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic [127:0] s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: res_num[31:0], res_den[63:32]
  output logic [63:0]  m_axis_tdata,
  // tuser: div_zero[0]
  output logic         m_axis_tuser
);
  import rag_pkg::*;
  `include "rational_arith_gcd_reduce_macros.svh"

  state_t      state, state_next;
  logic [2:0]  cmd;
  logic [31:0] an, ad, bn, bd;
  logic [31:0] ga, gb, g;
  logic [31:0] p1, p2;
  logic [31:0] res_num, res_den;
  logic        div_zero;
  logic [31:0] ma, mb, prod;
  div_req_t    dreq;
  div_rsp_t    drsp;

  rag_multiplier u_mul (.clk(clk), .op_a(ma), .op_b(mb), .prod(prod));
  rag_divider    u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {res_den, res_num};
  assign m_axis_tuser  = div_zero;

  // Multiplier operand selection by cycle.
  always_comb begin
    ma = an;
    mb = bd;
    case (state)
      ST_MUL1: begin ma = an; mb = (cmd == CMD_MUL) ? bn : bd; end
      ST_MUL2: begin ma = bn; mb = ad; end
      ST_MUL3: begin ma = ad; mb = (cmd == CMD_DIV) ? bn : bd; end
      default: begin ma = an; mb = bd; end
    endcase
  end

  // Next state and divider requests.
  always_comb begin
    state_next = state;
    dreq = '0;
    case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        case (s_axis_tuser)
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: state_next = ST_MUL1;
          CMD_RED: state_next = (s_axis_tdata[63:32] == 32'd0) ? ST_OUT : ST_GCD_START;
          default: state_next = ST_OUT;
        endcase
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_MUL4;
      ST_MUL4: state_next = ST_OUT;
      ST_GCD_START: begin
        dreq = '{start: 1'b1, dividend: ga, divisor: gb};
        state_next = ST_GCD_WAIT;
      end
      ST_GCD_WAIT: if (drsp.done) begin
        if (drsp.rem != 32'd0) state_next = ST_GCD_START;
        else if (gb == 32'd1) state_next = ST_OUT;
        else state_next = ST_QN_START;
      end
      ST_QN_START: begin
        dreq = '{start: 1'b1, dividend: an, divisor: g};
        state_next = ST_QN_WAIT;
      end
      ST_QN_WAIT: if (drsp.done) state_next = ST_QD_START;
      ST_QD_START: begin
        dreq = '{start: 1'b1, dividend: ad, divisor: g};
        state_next = ST_QD_WAIT;
      end
      ST_QD_WAIT: if (drsp.done) state_next = ST_OUT;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        cmd      <= s_axis_tuser;
        an       <= s_axis_tdata[31:0];
        ad       <= s_axis_tdata[63:32];
        bn       <= s_axis_tdata[95:64];
        bd       <= s_axis_tdata[127:96];
        ga       <= s_axis_tdata[31:0];
        gb       <= s_axis_tdata[63:32];
        res_num  <= (s_axis_tuser == CMD_NEG) ? 32'd0 - s_axis_tdata[31:0]
                                              : s_axis_tdata[31:0];
        res_den  <= s_axis_tdata[63:32];
        div_zero <= (s_axis_tuser == CMD_RED) && (s_axis_tdata[63:32] == 32'd0);
      end
      ST_MUL2: p1 <= prod;
      ST_MUL3: p2 <= prod;
      ST_MUL4: begin
        res_den <= prod;
        case (cmd)
          CMD_ADD: res_num <= p1 + p2;
          CMD_SUB: res_num <= p1 - p2;
          default: res_num <= p1;
        endcase
      end
      ST_GCD_WAIT: if (drsp.done) begin
        if (drsp.rem != 32'd0) begin
          ga <= gb;
          gb <= drsp.rem;
        end else begin
          g <= gb;
        end
      end
      ST_QN_WAIT: if (drsp.done) res_num <= drsp.quot;
      ST_QD_WAIT: if (drsp.done) res_den <= drsp.quot;
      default: ;
    endcase
  end

  `RAG_ASSERT_IMP(a_busy_not_ready, state != ST_IDLE, !s_axis_tready, "ready while busy")
  `RAG_ASSERT_NXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  `RAG_ASSERT_IMP(a_dz_reduce, m_axis_tvalid && m_axis_tuser, cmd == CMD_RED && res_den == 32'd0, "bad flag")
  `RAG_ASSERT_IMP(a_div_nonzero, dreq.start, dreq.divisor != 32'd0, "divide by zero")
endmodule

@@ bench/testbench.sv @@
// Testbench for the fraction unit: directed and random beats checked against a predictor.
module testbench;
  import rag_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // tdata: a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  logic [127:0] s_axis_tdata;
  // tuser: cmd[2:0]
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // tdata: res_num[31:0], res_den[63:32]
  logic [63:0]  m_axis_tdata;
  // tuser: div_zero[0]
  logic         m_axis_tuser;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        dz;
  } frac_res_t;

  frac_res_t   expected_fracs[$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  localparam int CYCLE_LIMIT = 20000000;
  localparam logic [31:0] MIN_INT = 32'h8000_0000;
  localparam logic [31:0] MAX_INT = 32'h7fff_ffff;

  rational_arith_gcd_reduce i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Magnitude, truncated remainder and quotient on 32-bit two's-complement words.
  function automatic logic [31:0] magnitude(logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  function automatic logic [31:0] trunc_rem(logic [31:0] x, logic [31:0] y);
    logic [31:0] r;
    r = magnitude(x) % magnitude(y);
    return x[31] ? -r : r;
  endfunction

  function automatic logic [31:0] trunc_quot(logic [31:0] x, logic [31:0] y);
    logic [31:0] q;
    q = magnitude(x) / magnitude(y);
    return (x[31] != y[31]) ? -q : q;
  endfunction

  // Predicts the fraction the block returns for one command beat.
  function automatic frac_res_t predict_fraction(logic [2:0] cmd, logic [31:0] an,
                                                 logic [31:0] ad, logic [31:0] bn,
                                                 logic [31:0] bd);
    frac_res_t   res;
    logic [31:0] x, y, r;
    res.num = an;
    res.den = ad;
    res.dz  = 1'b0;
    case (cmd)
      CMD_ADD: begin
        res.num = an * bd + bn * ad;
        res.den = ad * bd;
      end
      CMD_SUB: begin
        res.num = an * bd - bn * ad;
        res.den = ad * bd;
      end
      CMD_MUL: begin
        res.num = an * bn;
        res.den = ad * bd;
      end
      CMD_DIV: begin
        res.num = an * bd;
        res.den = ad * bn;
      end
      CMD_NEG: res.num = -an;
      CMD_RED: begin
        if (ad == 32'd0) begin
          res.dz = 1'b1;
        end else begin
          // Euclid chain; the sign of the gcd follows the remainders.
          x = an;
          y = ad;
          r = trunc_rem(x, y);
          while (r != 32'd0) begin
            x = y;
            y = r;
            r = trunc_rem(x, y);
          end
          if (y != 32'd1) begin
            res.num = trunc_quot(an, y);
            res.den = trunc_quot(ad, y);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Sends one beat, with random idle cycles before it. Valid stays high after
  // the accepting edge so that the next beat can follow directly.
  task automatic send_beat(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {bd, bn, ad, an};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_fracs.push_back(predict_fraction(cmd, an, ad, bn, bd));
  endtask

  // Drops valid once no further beat follows.
  task automatic release_bus();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return MIN_INT;
      1: return MAX_INT;
      2: return $urandom_range(8) - 4;
      3: return $urandom_range(200);
      4: return -$urandom_range(200);
      default: return $urandom;
    endcase
  endfunction

  // Random beat of any command; for reduce, half the time the fractions share a factor, so reduce has real work to do.
  task automatic send_random_beat();
    logic [31:0] g, an, ad;
    logic [2:0]  cmd;
    cmd = 3'($urandom_range(7));
    if (cmd == CMD_RED && $urandom_range(1)) begin
      g = $urandom_range(1000) - 500;
      an = g * ($urandom_range(4000) - 2000);
      ad = g * ($urandom_range(4000) - 2000);
    end else begin
      an = rand_word();
      ad = rand_word();
    end
    send_beat(cmd, an, ad, rand_word(), rand_word());
  endtask

  task automatic wait_drained();
    release_bus();
    @(posedge clk);
    while (expected_fracs.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_beat(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_beat(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
    send_beat(CMD_MUL, MAX_INT, 32'd2, MAX_INT, 32'd3);
    send_beat(CMD_DIV, MIN_INT, 32'd5, -32'd1, 32'd0);
    send_beat(CMD_ADD, MIN_INT, MIN_INT, MAX_INT, MAX_INT);
    send_beat(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CMD_NEG, MIN_INT, 32'd7, 32'd0, 32'd0);
    send_beat(CMD_NEG, 32'd5, -32'd3, 32'd1, 32'd1);
    send_beat(CMD_RED, 32'd12, 32'd0, 32'd0, 32'd0);
    send_beat(CMD_RED, 32'd12, 32'd18, 32'd0, 32'd0);
    send_beat(CMD_RED, -32'd12, 32'd18, 32'd0, 32'd0);
    send_beat(CMD_RED, 32'd12, -32'd18, 32'd0, 32'd0);
    send_beat(CMD_RED, MIN_INT, -32'd1, 32'd0, 32'd0);
    send_beat(CMD_RED, MIN_INT, MIN_INT, 32'd0, 32'd0);
    send_beat(CMD_RED, MAX_INT, MIN_INT, 32'd0, 32'd0);
    send_beat(CMD_RED, 32'd0, 32'd5, 32'd0, 32'd0);
    send_beat(CMD_RED, 32'd7, 32'd13, 32'd0, 32'd0);
    send_beat(CMD_RED, 32'd1836311903, 32'd1134903170, 32'd0, 32'd0);
    send_beat(3'd6, 32'd3, 32'd4, 32'd5, 32'd6);
    send_beat(3'd7, 32'hffff_ffff, 32'd0, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_beat();
  endtask

  // The sender holds off until every result is back, then resumes.
  task automatic test_drain_pause();
    wait_drained();
    repeat (5) send_random_beat();
  endtask

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    frac_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_fracs.size() == 0) begin
        $display("ERROR at cycle %0d: result beat with none expected", cycle_count);
        error_count++;
      end else begin
        want = expected_fracs.pop_front();
        if (m_axis_tdata[31:0] !== want.num)
          report_mismatch("res_num", m_axis_tdata[31:0], want.num);
        if (m_axis_tdata[63:32] !== want.den)
          report_mismatch("res_den", m_axis_tdata[63:32], want.den);
        if (m_axis_tuser !== want.dz)
          report_mismatch("div_zero", {31'd0, m_axis_tuser}, {31'd0, want.dz});
      end
    end
  end

  // Receiver stalls and cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rational_arith_gcd_reduce: mismatch");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 200);
    test_drain_pause();
    test_random_phase(49, 0, 200);
    test_random_phase(0, 49, 200);
    test_random_phase(34, 34, 200);
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_fracs.size() == 0) begin
      $display("rational_arith_gcd_reduce: match");
    end else begin
      $display("rational_arith_gcd_reduce: mismatch");
    end
    $finish;
  end
endmodule
